// ===== hdl/dsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types for the duration statistics monitor.
// ----------------------------------------------------------------------------
package dsm_pkg;

    localparam int unsigned TS_W       = 64;
    localparam int unsigned DELTA_W    = 32;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned SUM_W      = 64;
    localparam int unsigned DEADLINE_W = 31;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STOP  = 1'b1
    } dsm_action_t;

    // Only the low bits of the timestamp reach the duration.
    typedef struct packed {
        dsm_action_t          action;
        logic [DELTA_W-1:0]   ts_low;
    } dsm_event_t;

    typedef struct packed {
        logic                      running;
        logic                      measured;
        logic signed [DELTA_W-1:0] last_delta;
        logic                      missed_now;
        logic [CNT_W-1:0]          total_count;
        logic [CNT_W-1:0]          miss_count;
        logic signed [DELTA_W-1:0] min_duration;
        logic signed [DELTA_W-1:0] max_duration;
        logic signed [SUM_W-1:0]   duration_sum;
    } dsm_result_t;

endpackage

// ===== hdl/dsm_stats.sv =====
// ----------------------------------------------------------------------------
// dsm_stats
// Measurement state and statistics update for one event per cycle while evt_fire is high.
// ----------------------------------------------------------------------------
module dsm_stats
    import dsm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  evt_fire,
    input  dsm_event_t            evt,
    input  logic [DEADLINE_W-1:0] deadline,
    output dsm_result_t           result
);

    logic                      running_reg, running_next;
    logic [DELTA_W-1:0]        start_reg, start_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          miss_reg, miss_next;
    logic signed [DELTA_W-1:0] min_reg, min_next;
    logic signed [DELTA_W-1:0] max_reg, max_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;

    logic signed [DELTA_W-1:0] delta;
    logic                      stop_hit;
    logic                      late;

    assign delta    = $signed(evt.ts_low - start_reg);
    assign stop_hit = (evt.action == ACT_STOP) && running_reg;
    assign late     = delta > $signed({1'b0, deadline});

    always_comb begin
        running_next = running_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        miss_next    = miss_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        sum_next     = sum_reg;
        if (evt.action == ACT_START) begin
            if (!running_reg) begin
                running_next = 1'b1;
                start_next   = evt.ts_low;
            end
        end else if (running_reg) begin
            running_next = 1'b0;
            count_next   = count_reg + CNT_W'(1);
            sum_next     = sum_reg + SUM_W'(delta);
            if (late) begin
                miss_next = miss_reg + CNT_W'(1);
            end
            if ((min_reg == '0) || (delta < min_reg)) begin
                min_next = delta;
            end
            if ((max_reg == '0) || (delta > max_reg)) begin
                max_next = delta;
            end
        end
    end

    always_comb begin
        result.running      = running_next;
        result.measured     = stop_hit;
        result.last_delta   = stop_hit ? delta : '0;
        result.missed_now   = stop_hit && late;
        result.total_count  = count_next;
        result.miss_count   = miss_next;
        result.min_duration = min_next;
        result.max_duration = max_next;
        result.duration_sum = sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            start_reg   <= '0;
            count_reg   <= '0;
            miss_reg    <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            sum_reg     <= '0;
        end else if (evt_fire) begin
            running_reg <= running_next;
            start_reg   <= start_next;
            count_reg   <= count_next;
            miss_reg    <= miss_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            sum_reg     <= sum_next;
        end
    end

endmodule

// ===== hdl/duration_stats_monitor_unit.sv =====
// Data path: the input beat is held in the input register, its result in the result register.
// Throughput: one event per cycle while m_ready does not stall; the statistics update
// is a single pass of one 32-bit subtract, one 64-bit add and three 32-bit compares.
// Reset: synchronous active-low aresetn clears both valid flags, the deadline
// register and all measurement state; no item is held off after reset.
// ----------------------------------------------------------------------------
// duration_stats_monitor_unit
// Start/stop duration monitor with count, sum, min, max and deadline misses.
// ----------------------------------------------------------------------------
module duration_stats_monitor_unit
    import dsm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [DEADLINE_W-1:0]     cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [TS_W-1:0]           s_timestamp,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_running,
    output logic                      m_measured,
    output logic signed [DELTA_W-1:0] m_last_delta,
    output logic                      m_missed_now,
    output logic [CNT_W-1:0]          m_total_count,
    output logic [CNT_W-1:0]          m_miss_count,
    output logic signed [DELTA_W-1:0] m_min_duration,
    output logic signed [DELTA_W-1:0] m_max_duration,
    output logic signed [SUM_W-1:0]   m_duration_sum
);

    logic [DEADLINE_W-1:0] deadline_reg;
    logic                  in_valid_reg;
    dsm_event_t            in_evt_reg;
    logic                  out_valid_reg;
    dsm_result_t           out_res_reg;
    dsm_result_t           stats_res;
    logic                  out_free;
    logic                  fire;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadline_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            deadline_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_evt_reg.action <= dsm_action_t'(s_action);
            in_evt_reg.ts_low <= s_timestamp[DELTA_W-1:0];
        end
    end

    dsm_stats u_stats (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .evt_fire (fire),
        .evt      (in_evt_reg),
        .deadline (deadline_reg),
        .result   (stats_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= stats_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_running      = out_res_reg.running;
    assign m_measured     = out_res_reg.measured;
    assign m_last_delta   = out_res_reg.last_delta;
    assign m_missed_now   = out_res_reg.missed_now;
    assign m_total_count  = out_res_reg.total_count;
    assign m_miss_count   = out_res_reg.miss_count;
    assign m_min_duration = out_res_reg.min_duration;
    assign m_max_duration = out_res_reg.max_duration;
    assign m_duration_sum = out_res_reg.duration_sum;

endmodule

// ===== test/duration_stats_monitor_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// duration_stats_monitor_checker
// Watches the config, event and result channels of the duration monitor,
// keeps its own copy of the statistics and compares every result beat.
// ----------------------------------------------------------------------------
module duration_stats_monitor_checker
    import dsm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [DEADLINE_W-1:0]     cfg_wdata,

    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_action,
    input  logic [TS_W-1:0]           s_timestamp,

    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_running,
    input  logic                      m_measured,
    input  logic signed [DELTA_W-1:0] m_last_delta,
    input  logic                      m_missed_now,
    input  logic [CNT_W-1:0]          m_total_count,
    input  logic [CNT_W-1:0]          m_miss_count,
    input  logic signed [DELTA_W-1:0] m_min_duration,
    input  logic signed [DELTA_W-1:0] m_max_duration,
    input  logic signed [SUM_W-1:0]   m_duration_sum,

    output int                        fail_count,
    output int                        pending_count
);

    logic                  run_q;
    logic [TS_W-1:0]       start_q;
    logic [CNT_W-1:0]      done_q;
    logic [CNT_W-1:0]      miss_q;
    logic [DELTA_W-1:0]    min_q;
    logic [DELTA_W-1:0]    max_q;
    logic [SUM_W-1:0]      sum_q;
    logic [DEADLINE_W-1:0] deadline_q;
    dsm_result_t           stats_expected_q[$];
    dsm_result_t           want;
    int                    mismatches = 0;

    function automatic dsm_result_t advance_stats(input dsm_action_t act,
                                                  input logic [TS_W-1:0] ts);
        dsm_result_t        r;
        logic [TS_W-1:0]    span;
        logic [DELTA_W-1:0] d;
        r = '0;
        if (act == ACT_START) begin
            if (!run_q) begin
                start_q = ts;
                run_q   = 1'b1;
            end
        end else if (run_q) begin
            span         = ts - start_q;
            d            = span[DELTA_W-1:0];
            run_q        = 1'b0;
            r.measured   = 1'b1;
            r.last_delta = d;
            done_q       = done_q + CNT_W'(1);
            sum_q        = sum_q + {{(SUM_W-DELTA_W){d[DELTA_W-1]}}, d};
            // negative spans never miss
            if (!d[DELTA_W-1] && d[DEADLINE_W-1:0] > deadline_q) begin
                r.missed_now = 1'b1;
                miss_q       = miss_q + CNT_W'(1);
            end
            // zero marks an empty min/max
            if (min_q == '0 || $signed(d) < $signed(min_q)) min_q = d;
            if (max_q == '0 || $signed(d) > $signed(max_q)) max_q = d;
        end
        r.running      = run_q;
        r.total_count  = done_q;
        r.miss_count   = miss_q;
        r.min_duration = min_q;
        r.max_duration = max_q;
        r.duration_sum = sum_q;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            if (mismatches < 10)
                $display("%0t %s mismatch: expected %h, got %h", $time, field, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            run_q      = 1'b0;
            start_q    = '0;
            done_q     = '0;
            miss_q     = '0;
            min_q      = '0;
            max_q      = '0;
            sum_q      = '0;
            deadline_q = '0;
            stats_expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) deadline_q = cfg_wdata;
            if (s_valid && s_ready)
                stats_expected_q.push_back(advance_stats(dsm_action_t'(s_action), s_timestamp));
            if (m_valid && m_ready) begin
                if (stats_expected_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t result beat with nothing expected", $time);
                    mismatches++;
                end else begin
                    want = stats_expected_q.pop_front();
                    check_field("running", 64'(want.running), 64'(m_running));
                    check_field("measured", 64'(want.measured), 64'(m_measured));
                    check_field("last_delta", 64'(want.last_delta), 64'(m_last_delta));
                    check_field("missed_now", 64'(want.missed_now), 64'(m_missed_now));
                    check_field("total_count", 64'(want.total_count),
                                64'(m_total_count));
                    check_field("miss_count", 64'(want.miss_count), 64'(m_miss_count));
                    check_field("min_duration", 64'(want.min_duration),
                                64'(m_min_duration));
                    check_field("max_duration", 64'(want.max_duration),
                                64'(m_max_duration));
                    check_field("duration_sum", want.duration_sum, m_duration_sum);
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= stats_expected_q.size();
    end

endmodule

// ===== test/duration_stats_monitor_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// duration_stats_monitor_unit_test
// Drives start/stop events and deadline writes into the duration monitor
// under random stalls on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module duration_stats_monitor_unit_test;
    import dsm_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 375;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [DEADLINE_W-1:0]     cfg_wdata   = '0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic                      s_action    = 1'b0;
    logic [TS_W-1:0]           s_timestamp = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic                      m_running;
    logic                      m_measured;
    logic signed [DELTA_W-1:0] m_last_delta;
    logic                      m_missed_now;
    logic [CNT_W-1:0]          m_total_count;
    logic [CNT_W-1:0]          m_miss_count;
    logic signed [DELTA_W-1:0] m_min_duration;
    logic signed [DELTA_W-1:0] m_max_duration;
    logic signed [SUM_W-1:0]   m_duration_sum;

    int                        fail_count;
    int                        pending_count;
    int                        send_idle_pct  = 33;
    int                        recv_idle_pct  = 52;
    logic                      hold_go        = 1'b0;
    logic                      rx_hold        = 1'b0;
    int                        cycle_count    = 0;
    logic [DEADLINE_W-1:0]     deadline_now   = '0;

    duration_stats_monitor_unit u_top (.*);

    duration_stats_monitor_checker u_checker (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver stall, counted here
    initial begin
        wait (hold_go);
        @(negedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge aclk);
        rx_hold <= 1'b0;
    end

    // one event beat; returns at the falling edge after acceptance
    task automatic send_event(input dsm_action_t act, input logic [TS_W-1:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_timestamp <= ts;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic measure(input logic [TS_W-1:0] t_start, input logic [TS_W-1:0] t_stop);
        send_event(ACT_START, t_start);
        send_event(ACT_STOP, t_stop);
    endtask

    // only while nothing is in flight
    task automatic write_deadline(input logic [DEADLINE_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid    <= 1'b1;
        cfg_wdata    <= value;
        deadline_now = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int items);
        int              counted;
        int              sel;
        logic [TS_W-1:0] t0;
        logic [TS_W-1:0] span;
        logic [31:0]     near;
        counted = 0;
        while (counted < items) begin
            sel = $urandom_range(99);
            t0  = {$urandom, $urandom};
            if (sel < 10) begin
                send_event(dsm_action_t'($urandom_range(1)), t0);
                counted += 1;
            end else begin
                case ($urandom_range(99)) inside
                    [0:39]: span = 64'($urandom_range(400));
                    [40:59]: begin
                        near = {1'b0, deadline_now} + $urandom_range(2) - 1;
                        span = {32'd0, near};
                    end
                    [60:74]: span = 64'd0 - 64'($urandom_range(400, 1));
                    [75:89]: span = {32'd0, $urandom};
                    default: span = {$urandom, $urandom};
                endcase
                send_event(ACT_START, t0);
                if (sel < 20) send_event(ACT_START, {$urandom, $urandom});
                send_event(ACT_STOP, t0 + span);
                counted += (sel < 20) ? 3 : 2;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_deadline(31'd50);
        send_event(ACT_STOP, '0);
        send_event(ACT_START, '0);
        send_event(ACT_START, 64'd1000);
        send_event(ACT_STOP, 64'd10);
        measure('1, 64'd5);
        measure(64'd100, 64'd100);
        measure('0, 64'h8000_0000);
        measure('0, 64'h7FFF_FFFF);
        measure(64'h1_0000_0000, 64'h1_0000_0005);
        measure('0, 64'hFFFF_FFFF);
        send_event(ACT_STOP, '1);
        measure(64'd200, 64'd250);
        measure(64'd200, 64'd251);

        write_deadline(31'($urandom_range(1000, 1)));
        run_phase(ITEMS_PER_PHASE);

        send_idle_pct = 52;
        recv_idle_pct <= 33;
        write_deadline('1);
        run_phase(ITEMS_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        write_deadline('0);
        hold_go <= 1'b1;
        run_phase(ITEMS_PER_PHASE);

        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== duration_stats_monitor_unit.f =====
hdl/dsm_pkg.sv
hdl/dsm_stats.sv
hdl/duration_stats_monitor_unit.sv
test/duration_stats_monitor_checker.sv
test/duration_stats_monitor_unit_test.sv
